[rtl/spkctr_pkg.sv]
// ----------------------------------------------------------------------------
// spkctr_pkg
// Shared types and constants for the Speck128/256 counter-mode cipher:
// word layouts, sequencer states, control bundle and register indexes.
// ----------------------------------------------------------------------------
package spkctr_pkg;

	// cipher geometry
	localparam int ROUNDS      = 34;
	localparam int IDX_W       = $clog2(ROUNDS);
	localparam int WORD_W      = 64;
	localparam int BLOCK_BYTES = 16;
	localparam int HALF_BYTES  = 8;
	localparam int CNT_W       = 5;
	localparam int ROT_X       = 8;
	localparam int ROT_Y       = 3;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 2'd3;

	// input word
	typedef struct packed {
		logic              first;
		logic [WORD_W-1:0] nonce_lo;
		logic [WORD_W-1:0] nonce_hi;
		logic [WORD_W-1:0] data_lo;
		logic [WORD_W-1:0] data_hi;
		logic [CNT_W-1:0]  byte_count;
	} in_t;

	// result word
	typedef struct packed {
		logic [WORD_W-1:0] out_lo;
		logic [WORD_W-1:0] out_hi;
		logic [CNT_W-1:0]  out_count;
	} out_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY,
		ST_PRE,
		ST_ENC,
		ST_FIN
	} state_t;

	// sequencer to datapath controls
	typedef struct packed {
		logic             key_step;
		logic             pre;
		logic             enc_step;
		logic             finish;
		logic [IDX_W-1:0] idx;
	} ctl_t;

endpackage

[rtl/spkctr_ram.sv]
// ----------------------------------------------------------------------------
// spkctr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spkctr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 34
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/spkctr_round.sv]
// ----------------------------------------------------------------------------
// spkctr_round
// One Speck128 round, shared by the key schedule and the block encryption.
// ----------------------------------------------------------------------------
module spkctr_round
	import spkctr_pkg::*;
(
	input  logic [WORD_W-1:0] x,
	input  logic [WORD_W-1:0] y,
	input  logic [WORD_W-1:0] k,
	output logic [WORD_W-1:0] x_next,
	output logic [WORD_W-1:0] y_next
);

	logic [WORD_W-1:0] x_rot;
	logic [WORD_W-1:0] y_rot;

	// rotate x right by 8, y left by 3
	assign x_rot = {x[ROT_X-1:0], x[WORD_W-1:ROT_X]};
	assign y_rot = {y[WORD_W-1-ROT_Y:0], y[WORD_W-1:WORD_W-ROT_Y]};

	// add, key mix, then feed x into y
	assign x_next = (x_rot + y) ^ k;
	assign y_next = y_rot ^ x_next;

endmodule

[rtl/spkctr_ctrl.sv]
// ----------------------------------------------------------------------------
// spkctr_ctrl
// Sequencer: key expansion steps, round key prefetch, round steps and the
// hand-off of the finished word to the output register.
// ----------------------------------------------------------------------------
module spkctr_ctrl
	import spkctr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic first,
	input  logic out_free,
	output logic ready,
	output ctl_t ctl
);

	state_t           state_q;
	state_t           state_d;
	logic [IDX_W-1:0] idx_q;
	logic             last_step;

	assign last_step = (idx_q == IDX_W'(ROUNDS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = first ? ST_KEY : ST_PRE;
				end
			end
			ST_KEY: begin
				if (last_step) begin
					state_d = ST_PRE;
				end
			end
			ST_PRE: begin
				state_d = ST_ENC;
			end
			ST_ENC: begin
				if (last_step) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				idx_q <= '0;
			end else if (state_q == ST_KEY || state_q == ST_ENC) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// outputs
	always_comb begin
		ready        = (state_q == ST_IDLE);
		ctl.key_step = (state_q == ST_KEY);
		ctl.pre      = (state_q == ST_PRE);
		ctl.enc_step = (state_q == ST_ENC);
		ctl.finish   = (state_q == ST_FIN);
		ctl.idx      = idx_q;
	end

endmodule

[rtl/speck128_256_ctr_cipher.sv]
// ----------------------------------------------------------------------------
// speck128_256_ctr_cipher
// Speck128/256 in counter mode, one 16-byte word in, one word out.
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  -------   -------------------------  --------------------------------
//  input     data_valid / data_stall    data_word   (in_t)
//  result    result_valid / result_stall result_word (out_t)
//  config    cfg_we                     cfg_index, cfg_data (key words)
//
// One shared round unit does one Speck round per cycle, for both the key
// schedule and the block encryption; round keys sit in a 34-entry RAM.
// A word without first shows its result after the prefetch, 34 rounds and
// the output hand-off, and the next word can enter once the sequencer is
// back in idle; a word with first runs the key schedule steps before these.
// data_stall is high from accept until the result is in the output
// register; that register lets the next word in while a result waits.
// Reset clears the key words, counter and handshake state; no RAM sweep.
// ----------------------------------------------------------------------------
module speck128_256_ctr_cipher
	import spkctr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 data_valid,
	output logic                 data_stall,
	input  in_t                  data_word,
	output logic                 result_valid,
	input  logic                 result_stall,
	output out_t                 result_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	logic              ready;
	logic              accept;
	logic              out_free;
	logic              finish_go;
	ctl_t              ctl;

	logic [WORD_W-1:0] key0_q, key1_q, key2_q, key3_q;
	logic [WORD_W-1:0] ctr_lo_q, ctr_hi_q;
	logic [WORD_W-1:0] x_q, y_q, l1_q, l2_q;
	in_t               data_q;
	out_t              out_q;
	logic              out_valid_q;

	logic [WORD_W-1:0] rk_rdata;
	logic [WORD_W-1:0] rnd_k;
	logic [WORD_W-1:0] rnd_x, rnd_y;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;

	logic [WORD_W-1:0] mask_lo, mask_hi;
	logic              full_blk;
	in_t               data_in;

	assign accept     = data_valid && ready;
	assign data_stall = !ready;
	assign out_free   = !out_valid_q || !result_stall;
	assign finish_go  = ctl.finish && out_free;
	assign full_blk   = (data_q.byte_count == CNT_W'(BLOCK_BYTES));

	// sequencer
	spkctr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.first    (data_word.first),
		.out_free (out_free),
		.ready    (ready),
		.ctl      (ctl)
	);

	// round key store
	assign ram_re    = ctl.pre || (ctl.enc_step && ctl.idx != IDX_W'(ROUNDS - 1));
	assign ram_raddr = ctl.pre ? '0 : ctl.idx + 1'b1;

	spkctr_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ROUNDS)
	) u_rk_ram (
		.clk   (clk),
		.we    (ctl.key_step),
		.waddr (ctl.idx),
		.wdata (y_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rk_rdata)
	);

	// shared round unit: step index as key in the schedule
	assign rnd_k = ctl.key_step ? WORD_W'(ctl.idx) : rk_rdata;

	spkctr_round u_round (
		.x      (x_q),
		.y      (y_q),
		.k      (rnd_k),
		.x_next (rnd_x),
		.y_next (rnd_y)
	);

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0;
			key1_q <= '0;
			key2_q <= '0;
			key3_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY0: key0_q <= cfg_data;
				CFG_KEY1: key1_q <= cfg_data;
				CFG_KEY2: key2_q <= cfg_data;
				CFG_KEY3: key3_q <= cfg_data;
				default:  key0_q <= key0_q;
			endcase
		end
	end

	// counter: nonce load on first, low word steps after a full block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_lo_q <= '0;
			ctr_hi_q <= '0;
		end else if (accept && data_word.first) begin
			ctr_lo_q <= data_word.nonce_lo;
			ctr_hi_q <= data_word.nonce_hi;
		end else if (finish_go && full_blk) begin
			ctr_lo_q <= ctr_lo_q + 1'b1;
		end
	end

	// captured input word, byte count saturated to a block
	always_comb begin
		data_in = data_word;
		if (data_word.byte_count > CNT_W'(BLOCK_BYTES)) begin
			data_in.byte_count = CNT_W'(BLOCK_BYTES);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= data_in;
		end
	end

	// round state: schedule rotates l words through x
	always_ff @(posedge clk) begin
		if (accept && data_word.first) begin
			x_q  <= key1_q;
			y_q  <= key0_q;
			l1_q <= key2_q;
			l2_q <= key3_q;
		end else if (ctl.key_step) begin
			x_q  <= l1_q;
			y_q  <= rnd_y;
			l1_q <= l2_q;
			l2_q <= rnd_x;
		end else if (ctl.pre) begin
			x_q <= ctr_hi_q;
			y_q <= ctr_lo_q;
		end else if (ctl.enc_step) begin
			x_q <= rnd_x;
			y_q <= rnd_y;
		end
	end

	// byte masks for a partial block
	always_comb begin
		for (int b = 0; b < HALF_BYTES; b++) begin
			mask_lo[8*b +: 8] = {8{data_q.byte_count > CNT_W'(b)}};
			mask_hi[8*b +: 8] = {8{data_q.byte_count > CNT_W'(b + HALF_BYTES)}};
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (finish_go) begin
			out_q.out_lo    <= (y_q ^ data_q.data_lo) & mask_lo;
			out_q.out_hi    <= (x_q ^ data_q.data_hi) & mask_hi;
			out_q.out_count <= data_q.byte_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result_word  = out_q;

	// checks
	a_fin_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		finish_go |=> result_valid)
		else $error("finished word not presented");

	a_ram_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.key_step |-> !ram_re)
		else $error("round key read during schedule write");

	a_ctr_step: assert property (@(posedge clk) disable iff (!arst_n)
		finish_go && full_blk |=> ctr_lo_q == $past(ctr_lo_q) + 64'd1)
		else $error("counter did not advance after full block");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.enc_step || ctl.key_step || ctl.pre |-> data_stall)
		else $error("input open while a word is in the rounds");

endmodule
